// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the JSON string unescape / UTF-8 decoder.
package jsu_pkg;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX   = 3'd2,
    MODE_UTF   = 3'd3,
    MODE_IDLE  = 3'd4
  } mode_t;

  // Error codes reported on the result channel
  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_NUL        = 4'd1,
    ERR_BAD_LEN    = 4'd2,
    ERR_STRAY_CONT = 4'd3,
    ERR_TOO_BIG    = 4'd4,
    ERR_BAD_CONT   = 4'd5,
    ERR_OVERLONG   = 4'd6,
    ERR_NUL_ESC    = 4'd7,
    ERR_BAD_ESC    = 4'd8,
    ERR_NUL_HEX    = 4'd9,
    ERR_BAD_HEX    = 4'd10
  } err_t;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_MIN_2B  = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3B  = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4B  = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_BASE  = 21'h010000;

  localparam logic [15:0] SURR_MASK = 16'hFC00;
  localparam logic [15:0] SURR_HIGH = 16'hD800;
  localparam logic [15:0] SURR_LOW  = 16'hDC00;

  // Special bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== design/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// JSON string body decoder: UTF-8 sequences and escapes to Unicode code points.
//
// Takes one string body byte per request and returns at most one result per
// byte. Throughput is one byte per clock: the whole decode of a byte is a
// single pass from the decoder state registers into the result register, and
// a new byte is taken whenever the result register is empty or being drained.
// The result of an accepted byte is registered and valid in the cycle after it. Bytes that only
// advance a sequence (backslash, the u after a backslash, UTF-8 lead and middle bytes, the first three
// hex digits) give no result. A closing quote gives a result with
// out_string_done set; a fault gives a result with a nonzero out_error_code.
// After either, bytes are swallowed until one arrives with in_string_start set.
module json_string_unescape_utf8 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  input  logic                      in_string_start,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [jsu_pkg::CP_W-1:0]  out_code_point,
  output logic                      out_replace_last,
  output logic                      out_string_done,
  output logic [3:0]                out_error_code
);
  import jsu_pkg::*;

  // Decoder state
  mode_t            mode_r,   mode_nxt;
  logic [1:0]       cont_r,   cont_nxt;
  logic [1:0]       seq_r,    seq_nxt;
  logic [CP_W-1:0]  acc_r,    acc_nxt;
  logic [1:0]       hcnt_r,   hcnt_nxt;
  logic [15:0]      hacc_r,   hacc_nxt;
  logic [9:0]       hsb_r,    hsb_nxt;
  logic             adj_r,    adj_nxt;

  // Result register
  logic             out_valid_r;
  logic [CP_W-1:0]  cp_r;
  logic             rep_r;
  logic             done_r;
  err_t             err_r;

  // Result of the current byte
  logic             res_valid;
  logic [CP_W-1:0]  res_cp;
  logic             res_rep;
  logic             res_done;
  err_t             res_err;

  // State as seen by this byte (string start clears it first)
  mode_t            e_mode;
  logic [1:0]       e_cont;
  logic [1:0]       e_seq;
  logic [CP_W-1:0]  e_acc;
  logic [1:0]       e_hcnt;
  logic [15:0]      e_hacc;
  logic [9:0]       e_hsb;
  logic             e_adj;

  logic             in_fire;
  logic [4:0]       hv;
  logic [CP_W-1:0]  acc_shift;
  logic [1:0]       cont_dec;
  logic [15:0]      hex_shift;
  logic             is_low_surr;
  logic             is_high_surr;
  err_t             utf_chk;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign e_mode = in_string_start ? MODE_PLAIN : mode_r;
  assign e_cont = in_string_start ? 2'd0 : cont_r;
  assign e_seq  = in_string_start ? 2'd0 : seq_r;
  assign e_acc  = in_string_start ? '0 : acc_r;
  assign e_hcnt = in_string_start ? 2'd0 : hcnt_r;
  assign e_hacc = in_string_start ? 16'd0 : hacc_r;
  assign e_hsb  = in_string_start ? 10'd0 : hsb_r;
  assign e_adj  = in_string_start ? 1'b0 : adj_r;

  // Shared datapath pieces
  assign hv           = hex_digit(in_byte);
  assign acc_shift    = {e_acc[CP_W-7:0], in_byte[5:0]};
  assign cont_dec     = e_cont - 2'd1;
  assign hex_shift    = {e_hacc[11:0], hv[3:0]};
  assign is_low_surr  = (hex_shift & SURR_MASK) == SURR_LOW;
  assign is_high_surr = (hex_shift & SURR_MASK) == SURR_HIGH;

  // Range check of a completed UTF-8 sequence
  always_comb begin
    utf_chk = ERR_NONE;
    if (e_seq == 2'd1 && acc_shift < CP_MIN_2B) begin
      utf_chk = ERR_OVERLONG;
    end else if (e_seq == 2'd2 && acc_shift < CP_MIN_3B) begin
      utf_chk = ERR_OVERLONG;
    end else if (e_seq == 2'd3) begin
      if (acc_shift < CP_MIN_4B) begin
        utf_chk = ERR_OVERLONG;
      end else if (acc_shift > CP_MAX) begin
        utf_chk = ERR_TOO_BIG;
      end
    end
  end

  // Next decoder state
  always_comb begin
    mode_nxt = e_mode;
    cont_nxt = e_cont;
    seq_nxt  = e_seq;
    acc_nxt  = e_acc;
    hcnt_nxt = e_hcnt;
    hacc_nxt = e_hacc;
    hsb_nxt  = e_hsb;
    adj_nxt  = e_adj;
    case (e_mode)
      MODE_PLAIN: begin
        if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
          mode_nxt = MODE_IDLE;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = MODE_ESC;
        end else if (in_byte < 8'h80) begin
          adj_nxt = 1'b0;
        end else if (in_byte < 8'hC0) begin
          mode_nxt = MODE_IDLE;
        end else if (in_byte < 8'hE0) begin
          seq_nxt  = 2'd1;
          cont_nxt = 2'd1;
          acc_nxt  = CP_W'(in_byte & 8'h1F);
          mode_nxt = MODE_UTF;
        end else if (in_byte < 8'hF0) begin
          seq_nxt  = 2'd2;
          cont_nxt = 2'd2;
          acc_nxt  = CP_W'(in_byte & 8'h0F);
          mode_nxt = MODE_UTF;
        end else if (in_byte < 8'hF5) begin
          seq_nxt  = 2'd3;
          cont_nxt = 2'd3;
          acc_nxt  = CP_W'(in_byte & 8'h07);
          mode_nxt = MODE_UTF;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_UTF: begin
        if (in_byte[7:6] != 2'b10) begin
          mode_nxt = MODE_IDLE;
        end else begin
          acc_nxt  = acc_shift;
          cont_nxt = cont_dec;
          if (cont_dec == 2'd0) begin
            if (utf_chk != ERR_NONE) begin
              mode_nxt = MODE_IDLE;
            end else begin
              mode_nxt = MODE_PLAIN;
              adj_nxt  = 1'b0;
            end
          end
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        case (in_byte)
          CH_BSL, CH_QUOTE, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
            adj_nxt = 1'b0;
          end
          CH_U: begin
            mode_nxt = MODE_HEX;
            hcnt_nxt = 2'd0;
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
      MODE_HEX: begin
        if (!hv[4]) begin
          mode_nxt = MODE_IDLE;
        end else begin
          hacc_nxt = hex_shift;
          if (e_hcnt != 2'd3) begin
            hcnt_nxt = e_hcnt + 2'd1;
          end else begin
            hcnt_nxt = 2'd0;
            mode_nxt = MODE_PLAIN;
            if (is_low_surr && e_adj) begin
              adj_nxt = 1'b0;
            end else if (is_high_surr) begin
              hsb_nxt = hex_shift[9:0];
              adj_nxt = 1'b1;
            end else begin
              adj_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        mode_nxt = e_mode;
      end
    endcase
  end

  // Result of the current byte
  always_comb begin
    res_valid = 1'b0;
    res_cp    = '0;
    res_rep   = 1'b0;
    res_done  = 1'b0;
    res_err   = ERR_NONE;
    case (e_mode)
      MODE_PLAIN: begin
        if (in_byte == CH_NUL) begin
          res_valid = 1'b1;
          res_err   = ERR_NUL;
        end else if (in_byte == CH_QUOTE) begin
          res_valid = 1'b1;
          res_done  = 1'b1;
        end else if (in_byte == CH_BSL) begin
          res_valid = 1'b0;
        end else if (in_byte < 8'h80) begin
          res_valid = 1'b1;
          res_cp    = CP_W'(in_byte);
        end else if (in_byte < 8'hC0) begin
          res_valid = 1'b1;
          res_err   = ERR_STRAY_CONT;
        end else if (in_byte < 8'hF5) begin
          res_valid = 1'b0;
        end else if (in_byte < 8'hF8) begin
          res_valid = 1'b1;
          res_err   = ERR_TOO_BIG;
        end else begin
          res_valid = 1'b1;
          res_err   = ERR_BAD_LEN;
        end
      end
      MODE_UTF: begin
        if (in_byte[7:6] != 2'b10) begin
          res_valid = 1'b1;
          res_err   = ERR_BAD_CONT;
        end else if (cont_dec == 2'd0) begin
          res_valid = 1'b1;
          res_err   = utf_chk;
          res_cp    = (utf_chk == ERR_NONE) ? acc_shift : '0;
        end
      end
      MODE_ESC: begin
        res_valid = 1'b1;
        case (in_byte)
          CH_BSL, CH_QUOTE, CH_SLASH: res_cp = CP_W'(in_byte);
          CH_B:    res_cp = CP_W'(8'h08);
          CH_F:    res_cp = CP_W'(8'h0C);
          CH_N:    res_cp = CP_W'(8'h0A);
          CH_R:    res_cp = CP_W'(8'h0D);
          CH_T:    res_cp = CP_W'(8'h09);
          CH_U:    res_valid = 1'b0;
          CH_NUL:  res_err = ERR_NUL_ESC;
          default: res_err = ERR_BAD_ESC;
        endcase
      end
      MODE_HEX: begin
        if (in_byte == CH_NUL) begin
          res_valid = 1'b1;
          res_err   = ERR_NUL_HEX;
        end else if (!hv[4]) begin
          res_valid = 1'b1;
          res_err   = ERR_BAD_HEX;
        end else if (e_hcnt == 2'd3) begin
          res_valid = 1'b1;
          if (is_low_surr && e_adj) begin
            res_cp  = {1'b0, e_hsb, hex_shift[9:0]} + SURR_BASE;
            res_rep = 1'b1;
          end else begin
            res_cp  = CP_W'(hex_shift);
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Advance decoder state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cont_r <= 2'd0;
      seq_r  <= 2'd0;
      acc_r  <= '0;
      hcnt_r <= 2'd0;
      hacc_r <= 16'd0;
      hsb_r  <= 10'd0;
      adj_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      cont_r <= cont_nxt;
      seq_r  <= seq_nxt;
      acc_r  <= acc_nxt;
      hcnt_r <= hcnt_nxt;
      hacc_r <= hacc_nxt;
      hsb_r  <= hsb_nxt;
      adj_r  <= adj_nxt;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      cp_r   <= res_cp;
      rep_r  <= res_rep;
      done_r <= res_done;
      err_r  <= res_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = cp_r;
  assign out_replace_last = rep_r;
  assign out_string_done  = done_r;
  assign out_error_code   = err_r;

  // A done or error result carries no code point
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_string_done || out_error_code != ERR_NONE)
      |-> out_code_point == '0 && !out_replace_last)
    else $error("done/error result carries payload");

  // A surrogate pair combines into the supplementary range
  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replace_last
      |-> out_code_point >= CP_MIN_4B && out_code_point <= CP_MAX)
    else $error("combined surrogate out of range");

  // A fault or closing quote parks the decoder
  a_park: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_valid && (res_done || res_err != ERR_NONE) |=> mode_r == MODE_IDLE)
    else $error("decoder not idle after end of string");

  // No new request while a result is stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // Idle mode never produces a result
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode_r == MODE_IDLE && !in_string_start |=> !out_valid)
    else $error("result produced in idle mode");

endmodule

// ===== sim/tb_json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// Testbench for the JSON string body decoder: self-checking, directed and random byte streams.
module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            rep;
    logic            done;
    logic [3:0]      err;
  } cp_result_t;

  localparam logic [7:0] ESC_CHARS [8] = '{CH_BSL, CH_QUOTE, CH_SLASH, CH_B,
                                           CH_F, CH_N, CH_R, CH_T};

  // Decoder state copy plus the code points still owed by the block
  class cp_scoreboard;
    mode_t       mode;
    logic [1:0]  cont_left;
    logic [1:0]  seq_len;
    logic [20:0] utf_acc;
    logic [1:0]  hex_cnt;
    logic [15:0] hex_acc;
    logic [9:0]  surr_bits;
    logic        surr_pending;
    cp_result_t  pending_cps[$];
    int unsigned n_mismatch;
    int unsigned n_decoded_bytes;

    function new();
      clear_state();
      n_mismatch = 0;
      n_decoded_bytes = 0;
    endfunction

    function void clear_state();
      mode = MODE_PLAIN;
      cont_left = '0;
      seq_len = '0;
      utf_acc = '0;
      hex_cnt = '0;
      hex_acc = '0;
      surr_bits = '0;
      surr_pending = 1'b0;
    endfunction

    function bit fault(input err_t e, output cp_result_t r);
      mode = MODE_IDLE;
      r = '0;
      r.err = e;
      return 1'b1;
    endfunction

    function bit emit(input logic [20:0] cp, output cp_result_t r);
      surr_pending = 1'b0;
      r = '0;
      r.cp = cp;
      return 1'b1;
    endfunction

    // Advance the decoder by one byte; return 1 when a result is due
    function bit decode_byte(input logic [7:0] b, input logic start, output cp_result_t r);
      int hv;
      logic [15:0] ch;
      r = '0;
      if (start) clear_state();
      case (mode)
        MODE_PLAIN: begin
          if (b == CH_NUL) return fault(ERR_NUL, r);
          if (b == CH_QUOTE) begin
            mode = MODE_IDLE;
            r.done = 1'b1;
            return 1'b1;
          end
          if (b == CH_BSL) begin
            mode = MODE_ESC;
            return 1'b0;
          end
          if (b < 8'h80) return emit({13'd0, b}, r);
          if (b < 8'hC0) return fault(ERR_STRAY_CONT, r);
          if (b < 8'hE0) begin
            seq_len = 2'd1; cont_left = 2'd1; utf_acc = {16'd0, b[4:0]};
          end else if (b < 8'hF0) begin
            seq_len = 2'd2; cont_left = 2'd2; utf_acc = {17'd0, b[3:0]};
          end else if (b < 8'hF5) begin
            seq_len = 2'd3; cont_left = 2'd3; utf_acc = {18'd0, b[2:0]};
          end else if (b < 8'hF8) begin
            return fault(ERR_TOO_BIG, r);
          end else begin
            return fault(ERR_BAD_LEN, r);
          end
          mode = MODE_UTF;
          return 1'b0;
        end
        MODE_UTF: begin
          if (b[7:6] != 2'b10) return fault(ERR_BAD_CONT, r);
          utf_acc = {utf_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left != 2'd0) return 1'b0;
          mode = MODE_PLAIN;
          if (seq_len == 2'd1 && utf_acc < CP_MIN_2B) return fault(ERR_OVERLONG, r);
          if (seq_len == 2'd2 && utf_acc < CP_MIN_3B) return fault(ERR_OVERLONG, r);
          if (seq_len == 2'd3) begin
            if (utf_acc < CP_MIN_4B) return fault(ERR_OVERLONG, r);
            if (utf_acc > CP_MAX) return fault(ERR_TOO_BIG, r);
          end
          return emit(utf_acc, r);
        end
        MODE_ESC: begin
          mode = MODE_PLAIN;
          case (b)
            CH_BSL:   return emit(21'h5C, r);
            CH_QUOTE: return emit(21'h22, r);
            CH_SLASH: return emit(21'h2F, r);
            CH_B:     return emit(21'h08, r);
            CH_F:     return emit(21'h0C, r);
            CH_N:     return emit(21'h0A, r);
            CH_R:     return emit(21'h0D, r);
            CH_T:     return emit(21'h09, r);
            CH_U: begin
              mode = MODE_HEX;
              hex_cnt = 2'd0;
              return 1'b0;
            end
            CH_NUL:   return fault(ERR_NUL_ESC, r);
            default:  return fault(ERR_BAD_ESC, r);
          endcase
        end
        MODE_HEX: begin
          if (b == CH_NUL) return fault(ERR_NUL_HEX, r);
          if (b >= 8'h30 && b <= 8'h39) hv = b - 8'h30;
          else if (b >= 8'h61 && b <= 8'h66) hv = b - 8'h61 + 10;
          else if (b >= 8'h41 && b <= 8'h46) hv = b - 8'h41 + 10;
          else return fault(ERR_BAD_HEX, r);
          hex_acc = {hex_acc[11:0], 4'(hv)};
          if (hex_cnt != 2'd3) begin
            hex_cnt = hex_cnt + 2'd1;
            return 1'b0;
          end
          hex_cnt = 2'd0;
          mode = MODE_PLAIN;
          ch = hex_acc;
          // Low half right after a high half: combine and overwrite
          if ((ch & SURR_MASK) == SURR_LOW && surr_pending) begin
            surr_pending = 1'b0;
            r.cp = {1'b0, surr_bits, ch[9:0]} + SURR_BASE;
            r.rep = 1'b1;
            return 1'b1;
          end
          if ((ch & SURR_MASK) == SURR_HIGH) begin
            surr_bits = ch[9:0];
            surr_pending = 1'b1;
            r.cp = {5'd0, ch};
            return 1'b1;
          end
          return emit({5'd0, ch}, r);
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_request(input logic [7:0] b, input logic start);
      cp_result_t r;
      if (start || mode != MODE_IDLE) n_decoded_bytes++;
      if (decode_byte(b, start, r)) pending_cps.push_back(r);
    endfunction

    function void report(input string what, input cp_result_t exp, input cp_result_t got);
      n_mismatch++;
      if (n_mismatch <= 10) begin
        $display("%0t: %s: expected cp=%h rep=%b done=%b err=%0d, got cp=%h rep=%b done=%b err=%0d",
                 $realtime, what, exp.cp, exp.rep, exp.done, exp.err,
                 got.cp, got.rep, got.done, got.err);
      end
    endfunction

    function void check_result(input cp_result_t got);
      cp_result_t exp;
      if (pending_cps.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      exp = pending_cps.pop_front();
      if (got.cp !== exp.cp || got.rep !== exp.rep || got.done !== exp.done ||
          got.err !== exp.err) begin
        report("result mismatch", exp, got);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_byte;
  logic            in_string_start;
  logic            out_valid;
  logic            out_ready;
  logic [CP_W-1:0] out_code_point;
  logic            out_replace_last;
  logic            out_string_done;
  logic [3:0]      out_error_code;

  cp_scoreboard sb;
  logic [7:0]   frame_q[$];
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  bit           hold_req;

  json_string_unescape_utf8 u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_string_start  (in_string_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_replace_last (out_replace_last),
    .out_string_done  (out_string_done),
    .out_error_code   (out_error_code)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Check results first: a result at this edge belongs to an earlier request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result({out_code_point, out_replace_last, out_string_done, out_error_code});
      end
      if (in_valid && in_ready) sb.note_request(in_byte, in_string_start);
    end
  end

  // Receiver: random back-pressure, plus one long hold when asked
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void put_utf8(input logic [20:0] cp, input int unsigned len);
    case (len)
      2: begin
        frame_q.push_back({3'b110, cp[10:6]});
        frame_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        frame_q.push_back({4'b1110, cp[15:12]});
        frame_q.push_back({2'b10, cp[11:6]});
        frame_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        frame_q.push_back({5'b11110, cp[20:18]});
        frame_q.push_back({2'b10, cp[17:12]});
        frame_q.push_back({2'b10, cp[11:6]});
        frame_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Push a \u escape with four hex digits of random case
  function automatic void put_uesc(input logic [15:0] v);
    logic [3:0] nib;
    frame_q.push_back(CH_BSL);
    frame_q.push_back(CH_U);
    for (int i = 3; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 10) frame_q.push_back(8'h30 + nib);
      else frame_q.push_back(($urandom_range(1) ? 8'h61 : 8'h41) + nib - 8'd10);
    end
  endfunction

  // Offer one byte, after a random gap, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_string_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic lead_start);
    foreach (frame_q[i]) send_byte(frame_q[i], lead_start && i == 0);
  endtask

  // Random strings: mostly well formed, some with noise, cuts or bad UTF-8
  task automatic run_random(input int unsigned goal);
    int unsigned stop_at;
    int unsigned n_elem;
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  b;
    stop_at = sb.n_decoded_bytes + goal;
    while (sb.n_decoded_bytes < stop_at) begin
      frame_q.delete();
      n_elem = $urandom_range(10);
      repeat (n_elem) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          do b = 8'($urandom_range(8'h7F, 8'h01)); while (b == CH_QUOTE || b == CH_BSL);
          frame_q.push_back(b);
        end else if (pick < 37) begin
          put_utf8(21'($urandom_range(21'h7FF, 21'h80)), 2);
        end else if (pick < 49) begin
          put_utf8(21'($urandom_range(21'hFFFF, 21'h800)), 3);
        end else if (pick < 59) begin
          put_utf8(21'($urandom_range(21'h10FFFF, 21'h10000)), 4);
        end else if (pick < 74) begin
          frame_q.push_back(CH_BSL);
          frame_q.push_back(ESC_CHARS[$urandom_range(7)]);
        end else if (pick < 86) begin
          put_uesc(16'($urandom));
        end else if (pick < 94) begin
          put_uesc(SURR_HIGH | 16'($urandom_range(10'h3FF)));
          put_uesc(SURR_LOW | 16'($urandom_range(10'h3FF)));
        end else begin
          case ($urandom_range(3))
            0: put_utf8(21'($urandom_range(21'h7F)), 2);
            1: put_utf8(21'($urandom_range(21'h7FF)), 3);
            2: put_utf8(21'($urandom_range(21'hFFFF)), 4);
            default: put_utf8(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
          endcase
        end
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        frame_q.push_back(CH_QUOTE);
      end else if (pick < 85) begin
        frame_q.insert($urandom_range(frame_q.size()), 8'($urandom_range(255)));
        frame_q.push_back(CH_QUOTE);
      end else if (pick < 95 && frame_q.size() != 0) begin
        // drop the tail so the next start lands mid-sequence
        cut = $urandom_range(frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom_range(255)));
      end
      send_frame(1'b1);
    end
  endtask

  initial begin
    int unsigned wait_cnt;
    sb = new();
    hold_req = 1'b0;
    tx_idle_pct = 33;
    rx_idle_pct = 80;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_string_start = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: no start from reset, two high halves, a pair, top code point,
    // closing quote, a byte after done, then two faults
    frame_q.delete();
    frame_q.push_back(8'h7F);
    put_uesc(16'hD800);
    put_uesc(16'hDBFF);
    put_uesc(16'hDC00);
    put_utf8(21'h10FFFF, 4);
    frame_q.push_back(CH_QUOTE);
    frame_q.push_back(8'h41);
    send_frame(1'b0);
    for (int k = 0; k < 2; k++) begin
      frame_q.delete();
      case (k)
        0: frame_q.push_back(8'hF6);
        default: begin
          frame_q.push_back(8'hE0);
          frame_q.push_back(CH_QUOTE);
        end
      endcase
      send_frame(1'b1);
    end

    // Random phases: receiver-heavy gaps, sender-heavy gaps, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 33; rx_idle_pct = 80; end
        1: begin tx_idle_pct = 80; rx_idle_pct = 33; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      run_random(470);
    end
    in_valid <= 1'b0;

    // Drain, then wait once more before the final check
    wait_cnt = 0;
    while (sb.pending_cps.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending_cps.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending_cps.size());
    end
    if (sb.n_mismatch == 0 && sb.pending_cps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== json_string_unescape_utf8.f =====
design/jsu_pkg.sv
design/json_string_unescape_utf8.sv
sim/tb_json_string_unescape_utf8.sv
